FILE: src/ppdc_pkg.sv
// Shared types and constants for the packet payload decrypt and check block.
// Holds the input and result item structs and the configuration register map.
// No dependencies.
package ppdc_pkg;

  // Configuration register map: register index is paddr[2].
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_FIXED_KEY = 1'b0;

  // One input item: an encrypted byte of the packet region.
  typedef struct packed {
    logic [7:0] cipher_byte;
    logic [7:0] random_key;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  // One result item: the decrypted byte and its packet flags.
  typedef struct packed {
    logic [7:0] plain_byte;
    logic       is_payload;
    logic       end_of_packet;
    logic       checksum_ok;
  } out_item_t;

endpackage

FILE: src/ppdc_datapath.sv
// Decryption datapath and per-packet chain state of the decrypt block.
// Turns one registered input item into one result item in a single pass.
// Depends on ppdc_pkg.
module ppdc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  ppdc_pkg::in_item_t item,
  input  logic [7:0]         fixed_key,
  output ppdc_pkg::out_item_t result
);
  import ppdc_pkg::*;

  logic [7:0] prev_cipher_r, prev_cipher_nxt;
  logic [7:0] prev_inner_r, prev_inner_nxt;
  logic [7:0] position_r, position_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] packet_key_r, packet_key_nxt;
  logic [7:0] expected_sum_r, expected_sum_nxt;

  logic [7:0] pc, pi, pos, sum, key;
  logic [7:0] inner, plain;

  // A packet start clears the chain and takes the new random key.
  always_comb begin
    pc  = item.first_byte ? 8'd0 : prev_cipher_r;
    pi  = item.first_byte ? 8'd0 : prev_inner_r;
    pos = item.first_byte ? 8'd0 : position_r;
    sum = item.first_byte ? 8'd0 : running_sum_r;
    key = item.first_byte ? item.random_key : packet_key_r;
  end

  // Two chained XOR layers, then the running payload sum.
  always_comb begin
    position_nxt     = pos + 8'd1;
    inner            = item.cipher_byte ^ (pc + fixed_key + position_nxt);
    plain            = inner ^ (pi + key + position_nxt);
    prev_cipher_nxt  = item.cipher_byte;
    prev_inner_nxt   = inner;
    packet_key_nxt   = key;
    expected_sum_nxt = item.first_byte ? plain : expected_sum_r;
    running_sum_nxt  = item.first_byte ? 8'd0 : sum + plain;
  end

  // Result fields; the checksum verdict shows only on the last byte.
  always_comb begin
    result.plain_byte    = plain;
    result.is_payload    = ~item.first_byte;
    result.end_of_packet = item.last_byte;
    result.checksum_ok   = item.last_byte && (running_sum_nxt == expected_sum_nxt);
  end

  // Chain state moves only when the item passes into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cipher_r  <= 8'd0;
      prev_inner_r   <= 8'd0;
      position_r     <= 8'd0;
      running_sum_r  <= 8'd0;
      packet_key_r   <= 8'd0;
      expected_sum_r <= 8'd0;
    end else if (advance) begin
      prev_cipher_r  <= prev_cipher_nxt;
      prev_inner_r   <= prev_inner_nxt;
      position_r     <= position_nxt;
      running_sum_r  <= running_sum_nxt;
      packet_key_r   <= packet_key_nxt;
      expected_sum_r <= expected_sum_nxt;
    end
  end

endmodule

FILE: src/packet_payload_decrypt_check_core.sv
// Top level of the packet payload decrypt and check block.
// Holds the input and result registers, the handshake and the config port.
// Depends on ppdc_pkg and ppdc_datapath.
//
// Usage: each input item carries one encrypted byte of a packet region; the
// item with first_byte set is the checksum byte and brings the packet key,
// the item with last_byte set closes the packet. Every input item gives
// exactly one result item with the decrypted byte, a payload flag, an end
// flag and, on the end item, the checksum verdict.
// Path: an accepted item waits in the input register, then passes into the result
// register; out_valid rises once it is there, and its result can then be taken.
// Throughput: one item per cycle while out_stall is low; the chain state update is
// the only loop and it closes through the chain state registers of the datapath.
// Stalls: while out_stall holds a waiting result, one more item still enters
// the input register; in_stall rises only when both registers are full.
// Reset (rst_n low, synchronous) empties both registers, clears the chain
// state and sets fixed_key to zero. The APB-style port writes fixed_key at
// byte address 0; write it only while the block is idle.
module packet_payload_decrypt_check_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ppdc_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ppdc_pkg::out_item_t                out_item,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppdc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ppdc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ppdc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import ppdc_pkg::*;

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  out_item_t  result;
  logic [7:0] fixed_key_r;
  logic       advance;
  logic       in_take;
  logic       cfg_write;

  // Configuration port: one register, always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FIXED_KEY);
  assign prdata    = (paddr[2] == REG_FIXED_KEY) ?
                     {{(CFG_DATA_W-8){1'b0}}, fixed_key_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_key_r <= 8'd0;
    end else if (cfg_write) begin
      fixed_key_r <= pwdata[7:0];
    end
  end

  // The input register moves on when the result register is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take || advance) begin
      in_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
  end

  ppdc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (in_item_r),
    .fixed_key (fixed_key_r),
    .result    (result)
  );

  // Result register holds its item while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: src/ppdc_checker.sv
// Port-level checks for the packet payload decrypt and check block.
// Watches only the top level's ports; bound to the top level below.
// Depends on ppdc_pkg.
module ppdc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ppdc_pkg::out_item_t out_item,
  input logic                pready
);
  import ppdc_pkg::*;

  // A stalled result item stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // The input side stalls only behind a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // The checksum verdict appears only on the end item.
  a_ok_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.end_of_packet |-> !out_item.checksum_ok)
    else $error("checksum_ok set before end of packet");

  // A packet with an empty payload passes exactly when its checksum is zero.
  a_empty_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_packet && !out_item.is_payload |->
      out_item.checksum_ok == (out_item.plain_byte == 8'd0))
    else $error("wrong verdict for checksum-only packet");

  // The config port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind packet_payload_decrypt_check_core ppdc_checker u_ppdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item),
  .pready    (pready)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for packet_payload_decrypt_check_core: a directed stimulus table, then random packets.
// Every result item is checked against a row's expectation or the in-bench two-layer XOR model.
// Depends on ppdc_pkg and the core RTL.
module tb_top;
  import ppdc_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] FIXED_KEY_ADDR = {REG_FIXED_KEY, 2'b00};
  localparam int DRAIN_TAIL = 4;

  // One row of the directed table; set_key loads a new fixed key before the item is sent.
  typedef struct {
    bit         set_key;
    logic [7:0] key;
    in_item_t   item;
    bit         has_exp;
    out_item_t  exp_res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Typed expectation that travels with the item currently offered.
  bit        row_has_exp;
  out_item_t row_exp;

  // Decryption model state and its copy of the fixed key.
  logic [7:0] key_model;
  logic [7:0] chain_cipher;
  logic [7:0] chain_inner;
  logic [7:0] chain_pos;
  logic [7:0] payload_sum;
  logic [7:0] pkt_key;
  logic [7:0] coded_sum;

  out_item_t pending_plain[$];
  out_item_t pred_res;
  out_item_t want;
  stim_row_t dir_rows[$];

  int n_fail = 0;
  int items_sent = 0;
  int results_seen = 0;
  int tx_max_gap = 19;
  int rx_max_gap = 19;
  int rx_hold = 0;

  always #10 clk = ~clk;

  packet_payload_decrypt_check_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Decrypts one byte and advances the chain, exactly as the block should.
  function automatic out_item_t decrypt_byte(input in_item_t it);
    logic [7:0] idx;
    logic [7:0] inner;
    logic [7:0] plain;
    out_item_t  res;
    if (it.first_byte) begin
      chain_cipher = 8'h00;
      chain_inner  = 8'h00;
      chain_pos    = 8'h00;
      payload_sum  = 8'h00;
      pkt_key      = it.random_key;
    end
    idx   = chain_pos + 8'd1;
    inner = it.cipher_byte ^ (chain_cipher + key_model + idx);
    plain = inner ^ (chain_inner + pkt_key + idx);
    if (it.first_byte) begin
      coded_sum = plain;
    end else begin
      payload_sum = payload_sum + plain;
    end
    res.plain_byte    = plain;
    res.is_payload    = !it.first_byte;
    res.end_of_packet = it.last_byte;
    res.checksum_ok   = it.last_byte && (payload_sum == coded_sum);
    chain_cipher = it.cipher_byte;
    chain_inner  = inner;
    chain_pos    = idx;
    return res;
  endfunction

  // Predict on every accepted input item and check every accepted result item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred_res = decrypt_byte(in_item);
        pending_plain.push_back(row_has_exp ? row_exp : pred_res);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_plain.size() == 0) begin
          $error("result item %h arrived with no expectation waiting", out_item);
          n_fail++;
        end else begin
          want = pending_plain.pop_front();
          if (out_item.plain_byte !== want.plain_byte) begin
            $error("plain_byte: expected %h, got %h", want.plain_byte, out_item.plain_byte);
            n_fail++;
          end
          if (out_item.is_payload !== want.is_payload) begin
            $error("is_payload: expected %b, got %b", want.is_payload, out_item.is_payload);
            n_fail++;
          end
          if (out_item.end_of_packet !== want.end_of_packet) begin
            $error("end_of_packet: expected %b, got %b", want.end_of_packet,
                   out_item.end_of_packet);
            n_fail++;
          end
          if (out_item.checksum_ok !== want.checksum_ok) begin
            $error("checksum_ok: expected %b, got %b", want.checksum_ok, out_item.checksum_ok);
            n_fail++;
          end
        end
      end
    end
  end

  // Result side: random stall per item, or a long hold when one is requested.
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else begin
        n = (rx_max_gap > 0) ? $urandom_range(rx_max_gap, 0) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one item after a random gap and returns at the edge that accepts it.
  task automatic send_byte(input in_item_t it, input bit has_exp, input out_item_t exp_res);
    int gap;
    gap = (tx_max_gap > 0) ? $urandom_range(tx_max_gap, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_item     <= it;
    row_has_exp <= has_exp;
    row_exp     <= exp_res;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stops offering items and waits until every result item has come back.
  task automatic wait_drain();
    in_valid    <= 1'b0;
    row_has_exp <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Writes fixed_key through the APB port; the upper data bits carry noise.
  task automatic write_fixed_key(input logic [7:0] key);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FIXED_KEY_ADDR;
    pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'h0, key};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    key_model = key;
    @(posedge clk);
  endtask

  // Reads fixed_key back and compares it with the model copy.
  task automatic check_fixed_key();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FIXED_KEY_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'h0, key_model}) begin
      $error("fixed_key readback: expected %h, got %h", {24'h0, key_model}, prdata);
      n_fail++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Encrypts and sends one packet region: checksum byte, then n_pay payload bytes.
  // A bad packet carries a wrong checksum; an open packet never sets last_byte.
  task automatic send_packet(input int n_pay, input bit good, input bit closed);
    logic [7:0] plain_seq[$];
    logic [7:0] rk;
    logic [7:0] sum;
    logic [7:0] pc;
    logic [7:0] pi;
    logic [7:0] idx;
    logic [7:0] inner;
    logic [7:0] b;
    in_item_t   it;
    int         k;
    rk  = 8'($urandom_range(255, 0));
    sum = 8'h00;
    for (k = 0; k < n_pay; k++) begin
      b = 8'($urandom_range(255, 0));
      plain_seq.push_back(b);
      sum = sum + b;
    end
    if (!good) sum = sum + 8'($urandom_range(255, 1));
    plain_seq.push_front(sum);
    pc = 8'h00;
    pi = 8'h00;
    for (k = 0; k <= n_pay; k++) begin
      idx   = k[7:0] + 8'd1;
      inner = plain_seq[k] ^ (pi + rk + idx);
      it.cipher_byte = inner ^ (pc + key_model + idx);
      it.random_key  = (k == 0) ? rk : 8'($urandom_range(255, 0));
      it.first_byte  = (k == 0);
      it.last_byte   = closed && (k == n_pay);
      pc = it.cipher_byte;
      pi = inner;
      send_byte(it, 1'b0, '0);
    end
  endtask

  task automatic add_row(input bit set_key, input logic [7:0] key, input logic [7:0] c,
                         input logic [7:0] rk, input bit f, input bit l, input bit has_exp,
                         input out_item_t exp_res);
    stim_row_t r;
    r.set_key = set_key;
    r.key     = key;
    r.item    = in_item_t'{c, rk, f, l};
    r.has_exp = has_exp;
    r.exp_res = exp_res;
    dir_rows.push_back(r);
  endtask

  // Run limit.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    logic [7:0] phase_key[6];
    int         gap_choice[3];
    in_item_t   it;
    int         ph;
    int         stop_at;
    int         r;
    int         k;
    int         n;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    row_has_exp = 1'b0;
    row_exp     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    key_model    = 8'h00;
    chain_cipher = 8'h00;
    chain_inner  = 8'h00;
    chain_pos    = 8'h00;
    payload_sum  = 8'h00;
    pkt_key      = 8'h00;
    coded_sum    = 8'h00;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_fixed_key();

    // Directed table, starting under the reset key of zero.
    // Payload without a start right after reset: the held zero state passes the byte through.
    add_row(0, 8'h00, 8'hFF, 8'h00, 0, 0, 1, out_item_t'{8'hFF, 1'b1, 1'b0, 1'b0});
    // Checksum-only packets: ok exactly when the decoded checksum is zero.
    add_row(0, 8'h00, 8'h00, 8'h00, 1, 1, 1, out_item_t'{8'h00, 1'b0, 1'b1, 1'b1});
    add_row(0, 8'h00, 8'hFF, 8'h00, 1, 1, 1, out_item_t'{8'hFF, 1'b0, 1'b1, 1'b0});
    add_row(0, 8'h00, 8'h01, 8'hFF, 1, 1, 1, out_item_t'{8'h00, 1'b0, 1'b1, 1'b1});
    // A packet with extreme cipher bytes and random_key noise on payload bytes.
    add_row(0, 8'h00, 8'hA5, 8'h5A, 1, 0, 0, '0);
    add_row(0, 8'h00, 8'h00, 8'hFF, 0, 0, 0, '0);
    add_row(0, 8'h00, 8'hFF, 8'h00, 0, 0, 0, '0);
    add_row(0, 8'h00, 8'h80, 8'hFF, 0, 0, 0, '0);
    add_row(0, 8'h00, 8'h7F, 8'h00, 0, 1, 0, '0);
    // Payload without a start after an ended packet continues the chain.
    add_row(0, 8'h00, 8'hFF, 8'hFF, 0, 0, 0, '0);
    add_row(0, 8'h00, 8'h00, 8'h00, 0, 1, 0, '0);
    // A new start in the middle of a packet restarts the chain.
    add_row(0, 8'h00, 8'h33, 8'h12, 1, 0, 0, '0);
    add_row(0, 8'h00, 8'hCC, 8'hED, 1, 0, 0, '0);
    add_row(0, 8'h00, 8'h55, 8'hAA, 0, 1, 0, '0);
    // Largest fixed key: both layers cancel to zero on the checksum byte.
    add_row(1, 8'hFF, 8'h00, 8'hFF, 1, 1, 1, out_item_t'{8'h00, 1'b0, 1'b1, 1'b1});
    add_row(0, 8'hFF, 8'hFF, 8'h00, 1, 0, 0, '0);
    add_row(0, 8'hFF, 8'h00, 8'hFF, 0, 0, 0, '0);
    add_row(0, 8'hFF, 8'hFF, 8'h00, 0, 1, 0, '0);
    // Top bit of the fixed key alone.
    add_row(1, 8'h80, 8'h80, 8'h80, 1, 1, 1, out_item_t'{8'h80, 1'b0, 1'b1, 1'b0});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_key) begin
        wait_drain();
        write_fixed_key(dir_rows[i].key);
        check_fixed_key();
      end
      send_byte(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp_res);
    end

    // Random phases, each under its own fixed key.
    phase_key[0] = 8'($urandom_range(255, 0));
    phase_key[1] = 8'h00;
    phase_key[2] = 8'hFF;
    phase_key[3] = 8'($urandom_range(255, 0));
    phase_key[4] = 8'($urandom_range(255, 0));
    phase_key[5] = 8'h80;
    gap_choice[0] = 0;
    gap_choice[1] = 3;
    gap_choice[2] = 19;

    for (ph = 0; ph < 6; ph++) begin
      wait_drain();
      write_fixed_key(phase_key[ph]);
      check_fixed_key();
      tx_max_gap = (ph == 0) ? 19 : gap_choice[$urandom_range(2, 0)];
      rx_max_gap = (ph == 0) ? 19 : gap_choice[$urandom_range(2, 0)];

      // Long receiver hold while the sender keeps pushing, so the block backs up.
      // The receiver starts the hold right after the first result it takes.
      if (ph == 2) begin
        tx_max_gap = 0;
        rx_hold = 300;
        for (k = 0; k < 6; k++) send_packet($urandom_range(8, 4), 1'b1, 1'b1);
        tx_max_gap = gap_choice[$urandom_range(2, 0)];
      end

      // One packet long enough for the position counter to wrap.
      if (ph == 4) send_packet(260, 1'b1, 1'b1);

      stop_at = items_sent + 50;
      while (items_sent < stop_at) begin
        r = $urandom_range(99, 0);
        if (r < 12) begin
          n = $urandom_range(3, 1);
          for (k = 0; k < n; k++) begin
            it.cipher_byte = 8'($urandom_range(255, 0));
            it.random_key  = 8'($urandom_range(255, 0));
            it.first_byte  = 1'($urandom_range(1, 0));
            it.last_byte   = 1'($urandom_range(1, 0));
            send_byte(it, 1'b0, '0);
          end
        end else begin
          n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(9, 0);
          send_packet(n, r < 75, r < 92);
        end
      end
    end

    wait_drain();
    if (pending_plain.size() != 0) begin
      $error("%0d expected result items never arrived", pending_plain.size());
      n_fail++;
    end

    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
